// ===== rtl/radix_trie_word_map_macros.svh =====
// Assertion helpers for the word map.
`ifndef RADIX_TRIE_WORD_MAP_MACROS_SVH
`define RADIX_TRIE_WORD_MAP_MACROS_SVH

// Property checked every clock, off during reset.
`define RTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define RTW_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/rtw_pkg.sv =====
package rtw_pkg;

  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int ByteW = 8;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // control from sequencer to the allocator unit
  typedef struct packed {
    logic [1:0] need_inner;
    logic       need_leaf;
    logic       take_inner;
    logic       take_leaf;
    logic       clear;
  } alloc_ctl_t;

endpackage

// ===== rtl/radix_trie_word_map.sv =====
// Channel | Signals                              | Direction
// input   | in_valid, in_stall, command,key,value| into block
// output  | out_valid, out_stall, read_value,    | out of block
//         | status                               |
// Sequence: one pointer memory read per trie level, then for a write the
//   serial allocate/link steps; an unused command is answered from idle.
// Clear: one entry of each memory per cycle over max(INNER_NODES,LEAF_NODES)*256
//   addresses, then one result.
// Reset: the same sweep runs after rst; no item is taken until it ends.
// Stalls: one item at a time; a new item waits until the result is taken.
`include "radix_trie_word_map_macros.svh"

module radix_trie_word_map import rtw_pkg::*; #(
  parameter int INNER_NODES = 64,
  parameter int LEAF_NODES  = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      command,
  input  logic [KeyW-1:0] key,
  input  logic [ValW-1:0] value,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [ValW-1:0] read_value,
  output logic            status
);

  localparam int IW   = $clog2(INNER_NODES);
  localparam int LW   = $clog2(LEAF_NODES);
  localparam int PW   = (IW > LW) ? IW : LW;
  localparam int CIW  = $clog2(INNER_NODES + 1);
  localparam int CLW  = $clog2(LEAF_NODES + 1);
  localparam int CA   = IW + ByteW;
  localparam int LA   = LW + ByteW;
  localparam int MAXN = (INNER_NODES > LEAF_NODES) ? INNER_NODES : LEAF_NODES;
  localparam int SW   = $clog2(MAXN * 256);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_P1   = 4'd2;
  localparam logic [3:0] S_P2   = 4'd3;
  localparam logic [3:0] S_P3   = 4'd4;
  localparam logic [3:0] S_P4   = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_LV   = 4'd7;
  localparam logic [3:0] S_W1   = 4'd8;
  localparam logic [3:0] S_W2   = 4'd9;
  localparam logic [3:0] S_W3   = 4'd10;
  localparam logic [3:0] S_W4   = 4'd11;

  logic [3:0]      state;
  logic [1:0]      cmd;
  logic [KeyW-1:0] k;
  logic [ValW-1:0] val;
  logic [PW-1:0]   p1, p2, p3;
  logic [SW-1:0]   clr_cnt;
  logic            from_cmd;

  logic [CA-1:0]   cp_addr;
  logic            cp_we;
  logic [PW-1:0]   cp_wdata, cp_rdata;
  logic [LA-1:0]   lf_addr;
  logic            lf_we;
  logic [ValW-1:0] lf_rdata;

  alloc_ctl_t      actl;
  logic [CIW-1:0]  next_inner;
  logic [CLW-1:0]  next_leaf;
  logic            refuse;

  logic [ByteW-1:0] b0, b1, b2, b3;
  logic [PW-1:0]    p2_now, p3_now;
  logic             in_acc, clr_last;

  assign b0 = k[7:0];
  assign b1 = k[15:8];
  assign b2 = k[23:16];
  assign b3 = k[31:24];

  // child of level 1/2 is only real when its parent exists
  assign p2_now = (p1 != '0) ? cp_rdata : '0;
  assign p3_now = (p2 != '0) ? cp_rdata : '0;

  assign in_stall = (state != S_IDLE) || out_valid;
  assign in_acc   = in_valid && !in_stall;
  assign clr_last = (clr_cnt == SW'(MAXN * 256 - 1));

  rtw_ram #(.AW(CA), .DW(PW)) u_child (
    .clk(clk), .addr(cp_addr), .we(cp_we), .wdata(cp_wdata), .rdata(cp_rdata)
  );

  rtw_ram #(.AW(LA), .DW(ValW)) u_leaf (
    .clk(clk), .addr(lf_addr), .we(lf_we), .wdata(val), .rdata(lf_rdata)
  );

  rtw_alloc #(.INNER_NODES(INNER_NODES), .LEAF_NODES(LEAF_NODES)) u_alloc (
    .clk(clk), .rst(rst), .ctl(actl),
    .next_inner(next_inner), .next_leaf(next_leaf), .refuse(refuse)
  );

  // memory ports and allocator control, per state
  always_comb begin
    cp_addr  = '0;
    cp_we    = 1'b0;
    cp_wdata = '0;
    lf_addr  = '0;
    lf_we    = 1'b0;
    actl.need_inner = 2'(p1 == '0) + 2'(p2 == '0);
    actl.need_leaf  = (p3 == '0);
    actl.take_inner = 1'b0;
    actl.take_leaf  = 1'b0;
    actl.clear      = 1'b0;
    case (state)
      S_CLR: begin
        cp_addr  = clr_cnt[CA-1:0];
        lf_addr  = clr_cnt[LA-1:0];
        cp_we    = ({1'b0, clr_cnt} < (SW+1)'(INNER_NODES * 256));
        lf_we    = ({1'b0, clr_cnt} < (SW+1)'(LEAF_NODES * 256));
        actl.clear = clr_last;
      end
      S_P1: cp_addr = {IW'(0), b0};
      S_P2: cp_addr = {cp_rdata[IW-1:0], b1};
      S_P3: cp_addr = {p2_now[IW-1:0], b2};
      S_CHK: lf_addr = {p3[LW-1:0], b3};
      S_W1: begin
        cp_addr  = {IW'(0), b0};
        cp_wdata = PW'(next_inner);
        cp_we    = (p1 == '0);
        actl.take_inner = (p1 == '0);
      end
      S_W2: begin
        cp_addr  = {p1[IW-1:0], b1};
        cp_wdata = PW'(next_inner);
        cp_we    = (p2 == '0);
        actl.take_inner = (p2 == '0);
      end
      S_W3: begin
        cp_addr  = {p2[IW-1:0], b2};
        cp_wdata = PW'(next_leaf);
        cp_we    = (p3 == '0);
        actl.take_leaf = (p3 == '0);
      end
      S_W4: begin
        lf_addr = {p3[LW-1:0], b3};
        lf_we   = 1'b1;
      end
      default: ;
    endcase
  end

  // clear data with the memory sweep is zero
  // (leaf write data is val; force it off during sweep below)

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      from_cmd  <= 1'b0;
      out_valid <= 1'b0;
      val       <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cmd <= command;
            k   <= key;
            val <= (command == CMD_CLEAR) ? '0 : value;
            case (command)
              CMD_LOOKUP, CMD_WRITE: state <= S_P1;
              CMD_CLEAR: begin
                state    <= S_CLR;
                clr_cnt  <= '0;
                from_cmd <= 1'b1;
              end
              default: begin
                out_valid  <= 1'b1;
                read_value <= '0;
                status     <= 1'b0;
              end
            endcase
          end
        end
        S_CLR: begin
          val     <= '0;
          clr_cnt <= clr_cnt + SW'(1);
          if (clr_last) begin
            state <= S_IDLE;
            if (from_cmd) begin
              out_valid  <= 1'b1;
              read_value <= '0;
              status     <= 1'b0;
            end
            from_cmd <= 1'b0;
          end
        end
        S_P1: state <= S_P2;
        S_P2: begin
          p1    <= cp_rdata;
          state <= S_P3;
        end
        S_P3: begin
          p2    <= p2_now;
          state <= S_P4;
        end
        S_P4: begin
          p3    <= p3_now;
          state <= S_CHK;
        end
        S_CHK: begin
          if (cmd == CMD_LOOKUP) begin
            state <= S_LV;
          end else if (refuse) begin
            out_valid  <= 1'b1;
            read_value <= '0;
            status     <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_W1;
          end
        end
        S_LV: begin
          out_valid  <= 1'b1;
          read_value <= (p3 != '0) ? lf_rdata : '0;
          status     <= 1'b0;
          state      <= S_IDLE;
        end
        S_W1: begin
          if (p1 == '0) p1 <= PW'(next_inner);
          state <= S_W2;
        end
        S_W2: begin
          if (p2 == '0) p2 <= PW'(next_inner);
          state <= S_W3;
        end
        S_W3: begin
          if (p3 == '0) p3 <= PW'(next_leaf);
          state <= S_W4;
        end
        S_W4: begin
          out_valid  <= 1'b1;
          read_value <= '0;
          status     <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RTW_ASSERT(a_alloc_bound, (next_inner <= CIW'(INNER_NODES)) && (next_leaf <= CLW'(LEAF_NODES)), "allocator past pool")
  `RTW_ASSERT(a_refused_zero, (out_valid && status) |-> (read_value == '0), "refused write with data")
  `RTW_ASSERT_NEXT(a_busy_after_accept, in_acc && (command == CMD_LOOKUP || command == CMD_WRITE), state == S_P1, "item not started")
  `RTW_ASSERT(a_no_accept_in_sweep, (state == S_CLR) |-> !in_acc, "item taken during sweep")

endmodule

// ===== rtl/rtw_ram.sv =====
module rtw_ram import rtw_pkg::*; #(
  parameter int AW = 14,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/rtw_alloc.sv =====
module rtw_alloc import rtw_pkg::*; #(
  parameter int INNER_NODES = 64,
  parameter int LEAF_NODES  = 64,
  localparam int CIW = $clog2(INNER_NODES + 1),
  localparam int CLW = $clog2(LEAF_NODES + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  alloc_ctl_t     ctl,
  output logic [CIW-1:0] next_inner,
  output logic [CLW-1:0] next_leaf,
  output logic           refuse
);

  logic [CIW:0] inner_sum;
  logic [CLW:0] leaf_sum;

  // adders and compares: room check for a write path
  assign inner_sum = {1'b0, next_inner} + (CIW+1)'(ctl.need_inner);
  assign leaf_sum  = {1'b0, next_leaf} + (CLW+1)'(ctl.need_leaf);
  assign refuse = (inner_sum > (CIW+1)'(INNER_NODES)) ||
                  (leaf_sum > (CLW+1)'(LEAF_NODES));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      next_inner <= CIW'(1);
      next_leaf  <= CLW'(1);
    end else begin
      if (ctl.take_inner) begin
        next_inner <= next_inner + CIW'(1);
      end
      if (ctl.take_leaf) begin
        next_leaf <= next_leaf + CLW'(1);
      end
    end
  end

endmodule

// ===== bench/radix_trie_word_map_checker.sv =====
module radix_trie_word_map_checker import rtw_pkg::*; #(
  parameter int INNER_NODES = 64,
  parameter int LEAF_NODES  = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [1:0]      command,
  input  logic [KeyW-1:0] key,
  input  logic [ValW-1:0] value,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [ValW-1:0] read_value,
  input  logic            status,
  output int              errors,
  output int              pending
);

  localparam int Fanout = 256;
  localparam int PtrW = $clog2((INNER_NODES > LEAF_NODES) ? INNER_NODES : LEAF_NODES);

  typedef struct packed {
    logic [ValW-1:0] read_value;
    logic            status;
  } map_result_t;

  logic [PtrW-1:0] trie_ptr  [INNER_NODES*Fanout];
  logic [ValW-1:0] leaf_word [LEAF_NODES*Fanout];
  int              inner_next;
  int              leaf_next;
  map_result_t     results_due[$];

  function automatic void wipe_map();
    foreach (trie_ptr[i]) trie_ptr[i] = '0;
    foreach (leaf_word[i]) leaf_word[i] = '0;
    inner_next = 1;
    leaf_next  = 1;
  endfunction

  // Walk the trie one key byte per level and apply the command.
  function automatic map_result_t walk_trie(logic [1:0] cmd, logic [KeyW-1:0] k,
                                            logic [ValW-1:0] v);
    map_result_t r;
    int p1, p2, p3, need_i, need_l;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      wipe_map();
    end else if (cmd == CMD_LOOKUP || cmd == CMD_WRITE) begin
      p1 = trie_ptr[k[7:0]];
      p2 = p1 != 0 ? trie_ptr[p1*Fanout + k[15:8]] : 0;
      p3 = p2 != 0 ? trie_ptr[p2*Fanout + k[23:16]] : 0;
      if (cmd == CMD_LOOKUP) begin
        if (p1 != 0 && p2 != 0 && p3 != 0) r.read_value = leaf_word[p3*Fanout + k[31:24]];
      end else begin
        need_i = (p1 == 0) + (p2 == 0);
        need_l = (p3 == 0);
        if (inner_next + need_i > INNER_NODES || leaf_next + need_l > LEAF_NODES) begin
          r.status = 1'b1;
        end else begin
          if (p1 == 0) begin
            p1 = inner_next++;
            trie_ptr[k[7:0]] = PtrW'(p1);
          end
          if (p2 == 0) begin
            p2 = inner_next++;
            trie_ptr[p1*Fanout + k[15:8]] = PtrW'(p2);
          end
          if (p3 == 0) begin
            p3 = leaf_next++;
            trie_ptr[p2*Fanout + k[23:16]] = PtrW'(p3);
          end
          leaf_word[p3*Fanout + k[31:24]] = v;
        end
      end
    end
    return r;
  endfunction

  initial begin
    errors = 0;
    wipe_map();
  end

  assign pending = results_due.size();

  always @(posedge clk) begin
    map_result_t exp_r;
    if (!rst) begin
      if (in_valid && !in_stall) results_due.push_back(walk_trie(command, key, value));
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result with nothing expected: read_value %h status %b", read_value, status);
          errors = errors + 1;
        end else begin
          exp_r = results_due.pop_front();
          if (read_value !== exp_r.read_value) begin
            $error("read_value expected %h actual %h", exp_r.read_value, read_value);
            errors = errors + 1;
          end
          if (status !== exp_r.status) begin
            $error("status expected %b actual %b", exp_r.status, status);
            errors = errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_radix_trie_word_map.sv =====
module tb_radix_trie_word_map;
  import rtw_pkg::*;

  // Command code the block must ignore (no side effect, zero result).
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RandomItems = 1500;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      command = CMD_LOOKUP;
  logic [KeyW-1:0] key = '0;
  logic [ValW-1:0] value = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [ValW-1:0] read_value;
  logic            status;
  int              errors;
  int              pending;

  // Sender finished; set once the last item has been taken.
  bit              sent_all = 1'b0;
  // One long receiver hold-off is requested mid run.
  bit              hold_req = 1'b0;

  // Per-phase byte pools; small pools give shared prefixes so paths get deep.
  logic [7:0]      pool0[4], pool1[4], pool2[4];
  bit              no_gaps;

  always #5 clk = ~clk;

  radix_trie_word_map i_dut (
    .clk, .rst, .in_valid, .in_stall, .command, .key, .value,
    .out_valid, .out_stall, .read_value, .status
  );

  radix_trie_word_map_checker i_check (
    .clk, .rst, .in_valid, .in_stall, .command, .key, .value,
    .out_valid, .out_stall, .read_value, .status, .errors, .pending
  );

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(logic [1:0] cmd, logic [KeyW-1:0] k, logic [ValW-1:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1'b1;
    command  = cmd;
    key      = k;
    value    = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void refill_pools();
    foreach (pool0[i]) begin
      pool0[i] = 8'($urandom());
      pool1[i] = 8'($urandom());
      pool2[i] = 8'($urandom());
    end
    // Byte extremes show up often.
    pool0[0] = 8'h00;
    pool1[1] = 8'hff;
    pool2[2] = 8'h00;
    pool2[3] = 8'hff;
  endfunction

  // Key from the shared-prefix pools, or fully random to burn through nodes.
  function automatic logic [KeyW-1:0] pick_key();
    logic [7:0] b3;
    b3 = 8'($urandom());
    if ($urandom_range(0, 99) < 20) return $urandom();
    return {b3, pool2[$urandom_range(0, 3)], pool1[$urandom_range(0, 3)],
            pool0[$urandom_range(0, 3)]};
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;           // delete
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // Stimulus.
  initial begin
    int r;
    logic [KeyW-1:0] k;
    no_gaps = 1'b0;
    refill_pools();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every command, delete, unused command, clear.
    send_item(CMD_LOOKUP, '0, '0);
    send_item(CMD_WRITE,  '0, '1);
    send_item(CMD_LOOKUP, '0, '0);
    send_item(CMD_WRITE,  '1, 32'h0000_0001);
    send_item(CMD_LOOKUP, '1, '0);
    send_item(CMD_LOOKUP, 32'h00ff_ffff, '0);    // shares path, other word
    send_item(CMD_WRITE,  '0, '0);               // delete existing
    send_item(CMD_LOOKUP, '0, '0);
    send_item(CMD_WRITE,  32'h1234_5678, '0);    // delete of an absent key
    send_item(CMD_LOOKUP, 32'h1234_5678, '0);
    send_item(CMD_UNUSED, '1, '1);
    send_item(CMD_LOOKUP, '1, '0);
    send_item(CMD_CLEAR,  '1, '1);
    send_item(CMD_LOOKUP, '1, '0);
    send_item(CMD_LOOKUP, 32'h00ff_ffff, '0);

    // Random: phases of write/lookup traffic on shared prefixes, with unused
    // commands, random-key writes that exhaust the pools and a rare clear.
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 150 == 0) begin
        refill_pools();
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if (n == RandomItems / 3) hold_req = 1'b1;
      r = $urandom_range(0, 999);
      k = pick_key();
      if (r < 8) send_item(CMD_CLEAR, $urandom(), $urandom());
      else if (r < 30) send_item(CMD_UNUSED, $urandom(), $urandom());
      else if (r < 520) send_item(CMD_WRITE, k, pick_value());
      else send_item(CMD_LOOKUP, k, $urandom());
    end
    in_valid = 1'b0;
    sent_all = 1'b1;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: random stalls, stall-free stretches, one long hold-off.
  initial begin
    int r;
    int held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_req && held == 0) begin
        // Long stretch: the block fills and must stall its input.
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        held = 1;
      end
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) out_stall = 1'b0;
      else if (r < 95) out_stall = 1'b1;
      else begin
        out_stall = 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  // Watchdog.
  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
